// File: rtl/bjr_pkg.sv
// ----------------------------------------------------------------------------
// bjr_pkg: shared types, codes and fixed-point helpers
// Q16.16 saturating arithmetic, function codes, datapath commands.
// ----------------------------------------------------------------------------
package bjr_pkg;

  // function codes of an input transaction
  localparam logic [3:0] FN_ADD_POS   = 4'd0;
  localparam logic [3:0] FN_ADD_VEL   = 4'd1;
  localparam logic [3:0] FN_CLEAR     = 4'd2;
  localparam logic [3:0] FN_SCALE_POS = 4'd3;
  localparam logic [3:0] FN_SCALE_VEL = 4'd4;

  // bit positions inside a product function code
  localparam int unsigned FB_AMODE = 0;
  localparam int unsigned FB_VEL   = 1;
  localparam int unsigned FB_DAMP  = 2;
  localparam int unsigned FB_PROD  = 3;

  // configuration register indexes
  localparam logic [1:0] CFG_SELF_ID = 2'd0;
  localparam logic [1:0] CFG_MASS    = 2'd1;
  localparam logic [1:0] CFG_DAMP    = 2'd2;

  localparam logic [30:0] MASS_RESET = 31'd65536;
  localparam logic [3:0]  ELEM_LAST  = 4'd8;

  typedef struct packed {
    logic [3:0]         func;
    logic [19:0]        entry_id;
    logic signed [31:0] e0;
    logic signed [31:0] e1;
    logic signed [31:0] e2;
    logic signed [31:0] e3;
    logic signed [31:0] e4;
    logic signed [31:0] e5;
    logic signed [31:0] e6;
    logic signed [31:0] e7;
    logic signed [31:0] e8;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic               done_res;
    logic               table_full;
  } out_item_t;

  // datapath commands
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_LOOK,
    DP_ADD_RD,
    DP_ADD_WR,
    DP_CLR_WR,
    DP_SC_RD,
    DP_SC_MUL,
    DP_SC_WR,
    DP_HD_MUL,
    DP_HD_RND,
    DP_NH,
    DP_P_RD,
    DP_P_M,
    DP_P_MUL,
    DP_P_ACC,
    DP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [3:0] elem;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] func;
    logic       hit;
    logic       has_free;
    logic       out_free;
  } dp_status_t;

  // clamp a wide value to Q16.16
  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // round a raw Q32.32 product to nearest, ties up, and saturate
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd32768) >>> 16;
    return sat64(t);
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7fffffff;
    else return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7fffffff;
    else return s[31:0];
  endfunction

  // column (vector component) of a row-major block element
  function automatic logic [1:0] elem_col(input logic [3:0] elem);
    case (elem)
      4'd0, 4'd3, 4'd6: return 2'd0;
      4'd1, 4'd4, 4'd7: return 2'd1;
      default:          return 2'd2;
    endcase
  endfunction

  // row of a row-major block element
  function automatic logic [1:0] elem_row(input logic [3:0] elem);
    case (elem)
      4'd0, 4'd1, 4'd2: return 2'd0;
      4'd3, 4'd4, 4'd5: return 2'd1;
      default:          return 2'd2;
    endcase
  endfunction

  function automatic logic elem_diag(input logic [3:0] elem);
    return (elem == 4'd0) || (elem == 4'd4) || (elem == 4'd8);
  endfunction

endpackage

// File: rtl/bjr_if.sv
// ----------------------------------------------------------------------------
// bjr_if: valid/ready channels
// Input and result channels carrying one transaction per handshake.
// ----------------------------------------------------------------------------
interface bjr_in_if;
  logic               valid;
  logic               ready;
  bjr_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bjr_out_if;
  logic               valid;
  logic               ready;
  bjr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/bjr_datapath.sv
// ----------------------------------------------------------------------------
// bjr_datapath: key table, block memories and Q16.16 arithmetic
// Executes one command per cycle from the controller.
// ----------------------------------------------------------------------------
module bjr_datapath #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned ID_WIDTH    = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [30:0]                    cfg_data_i,
  input  bjr_pkg::in_item_t              item_i,
  input  bjr_pkg::dp_cmd_t               cmd_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0] ent_i,
  output bjr_pkg::dp_status_t            status_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bjr_pkg::out_item_t             out_data_o
);

  localparam int unsigned SW    = $clog2(MAX_ENTRIES);
  localparam int unsigned CW    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned DEPTH = MAX_ENTRIES * 9;
  localparam int unsigned AW    = $clog2(DEPTH);

  // configuration registers
  logic [19:0] self_id_q;
  logic [30:0] mass_q;
  logic [30:0] damp_q;

  // held transaction
  logic [3:0]          func_q;
  logic [ID_WIDTH-1:0] id_q;
  logic signed [31:0]  e_q [9];
  logic                last_q;

  // key table
  logic [ID_WIDTH-1:0]    key_q [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_q;
  logic [CW-1:0]          count_q;

  logic [SW-1:0] slot_q;
  logic          new_q;
  logic          full_q;
  logic          self_q;

  // block memories
  logic signed [31:0] pos_mem [DEPTH];
  logic signed [31:0] vel_mem [DEPTH];
  logic signed [31:0] rd_pos_q;
  logic signed [31:0] rd_vel_q;

  // arithmetic registers
  logic signed [63:0] mul_q;
  logic signed [31:0] hd_q;
  logic signed [31:0] nh_q;
  logic signed [31:0] m_q;
  logic signed [33:0] rsum_q;
  logic signed [31:0] acc_q [3];

  logic               out_valid_q;
  bjr_pkg::out_item_t out_q;

  // lookup
  logic                hit;
  logic [SW-1:0]       hit_slot;
  logic                has_free;
  logic [SW-1:0]       free_slot;
  logic [ID_WIDTH-1:0] self_key;

  assign self_key = ID_WIDTH'(self_id_q);

  always_comb begin
    hit       = 1'b0;
    hit_slot  = '0;
    has_free  = 1'b0;
    free_slot = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (valid_q[i] && (key_q[i] == id_q)) begin
        hit      = 1'b1;
        hit_slot = SW'(i);
      end
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        has_free  = 1'b1;
        free_slot = SW'(i);
      end
    end
  end

  // memory address: sweeps use the entry counter, others the found slot
  logic [SW-1:0] base_slot;
  logic [AW-1:0] addr;
  logic          sweep;

  assign sweep     = (cmd_i.op == bjr_pkg::DP_CLR_WR) || (cmd_i.op == bjr_pkg::DP_SC_RD) ||
                     (cmd_i.op == bjr_pkg::DP_SC_WR);
  assign base_slot = sweep ? ent_i : slot_q;
  assign addr      = AW'(AW'(base_slot) * AW'(9) + AW'(cmd_i.elem));

  // write data and enables
  logic               pos_we;
  logic               vel_we;
  logic signed [31:0] pos_wdata;
  logic signed [31:0] vel_wdata;
  logic signed [31:0] old_val;
  logic signed [31:0] elem_val;

  assign elem_val = e_q[cmd_i.elem];

  always_comb begin
    pos_we    = 1'b0;
    vel_we    = 1'b0;
    pos_wdata = '0;
    vel_wdata = '0;
    old_val   = new_q ? 32'sd0 : (func_q[0] ? rd_vel_q : rd_pos_q);
    case (cmd_i.op)
      // a new entry starts with both of its blocks zero
      bjr_pkg::DP_ADD_WR: begin
        pos_we = (func_q == bjr_pkg::FN_ADD_POS) || new_q;
        vel_we = (func_q == bjr_pkg::FN_ADD_VEL) || new_q;
        if (func_q == bjr_pkg::FN_ADD_POS) pos_wdata = bjr_pkg::sat_add(old_val, elem_val);
        else vel_wdata = bjr_pkg::sat_add(old_val, elem_val);
      end
      bjr_pkg::DP_CLR_WR: begin
        pos_we = 1'b1;
        vel_we = 1'b1;
      end
      bjr_pkg::DP_SC_WR: begin
        pos_we    = (func_q == bjr_pkg::FN_SCALE_POS);
        vel_we    = (func_q == bjr_pkg::FN_SCALE_VEL);
        pos_wdata = bjr_pkg::qround(mul_q);
        vel_wdata = bjr_pkg::qround(mul_q);
      end
      default: ;
    endcase
  end

  logic rd_en;
  assign rd_en = (cmd_i.op == bjr_pkg::DP_ADD_RD) || (cmd_i.op == bjr_pkg::DP_SC_RD) ||
                 (cmd_i.op == bjr_pkg::DP_P_RD);

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[addr] <= pos_wdata;
    if (vel_we) vel_mem[addr] <= vel_wdata;
    if (rd_en) begin
      rd_pos_q <= pos_mem[addr];
      rd_vel_q <= vel_mem[addr];
    end
  end

  // effective matrix element for the product
  logic signed [31:0] m_d;
  logic               self_diag;

  assign self_diag = self_q && bjr_pkg::elem_diag(cmd_i.elem);

  always_comb begin
    if (func_q[bjr_pkg::FB_AMODE]) begin
      m_d = bjr_pkg::sat_sub(32'sd0, rd_pos_q);
      if (func_q[bjr_pkg::FB_VEL]) m_d = bjr_pkg::sat_sub(m_d, rd_vel_q);
      if (self_diag) begin
        m_d = bjr_pkg::sat_add(m_d, $signed({1'b0, mass_q}));
        if (func_q[bjr_pkg::FB_DAMP]) m_d = bjr_pkg::sat_add(m_d, nh_q);
      end
    end else begin
      m_d = rd_pos_q;
      if (self_diag && func_q[bjr_pkg::FB_DAMP]) m_d = bjr_pkg::sat_add(m_d, hd_q);
    end
  end

  // damping scaled by (entries - 1)
  logic signed [CW:0]    n_s;
  logic signed [CW+32:0] n_prod;

  assign n_s    = $signed({1'b0, CW'(count_q - CW'(1))});
  assign n_prod = n_s * hd_q;

  // row accumulation
  logic [1:0]         col;
  logic [1:0]         row;
  logic signed [33:0] rsum_d;
  logic signed [31:0] rsum_sat;

  assign col      = bjr_pkg::elem_col(cmd_i.elem);
  assign row      = bjr_pkg::elem_row(cmd_i.elem);
  assign rsum_d   = ((col == 2'd0) ? 34'sd0 : rsum_q) + 34'(bjr_pkg::qround(mul_q));
  assign rsum_sat = bjr_pkg::sat64(64'(rsum_d));

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_id_q   <= '0;
      mass_q      <= bjr_pkg::MASS_RESET;
      damp_q      <= '0;
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      acc_q[0]    <= '0;
      acc_q[1]    <= '0;
      acc_q[2]    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bjr_pkg::CFG_SELF_ID: self_id_q <= cfg_data_i[19:0];
          bjr_pkg::CFG_MASS:    mass_q    <= cfg_data_i;
          bjr_pkg::CFG_DAMP:    damp_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if ((cmd_i.op == bjr_pkg::DP_LOOK) && !func_q[bjr_pkg::FB_PROD] &&
          (func_q[3:1] == 3'd0) && !hit && has_free) begin
        valid_q[free_slot] <= 1'b1;
        count_q            <= CW'(count_q + CW'(1));
      end
      if ((cmd_i.op == bjr_pkg::DP_P_ACC) && (col == 2'd2)) begin
        acc_q[row] <= bjr_pkg::sat_add(acc_q[row], rsum_sat);
      end
      if (cmd_i.op == bjr_pkg::DP_FIN) begin
        out_valid_q <= 1'b1;
        if (func_q[bjr_pkg::FB_PROD] && last_q) begin
          acc_q[0] <= '0;
          acc_q[1] <= '0;
          acc_q[2] <= '0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      bjr_pkg::DP_LOAD: begin
        func_q <= item_i.func;
        id_q   <= ID_WIDTH'(item_i.entry_id);
        e_q[0] <= item_i.e0;
        e_q[1] <= item_i.e1;
        e_q[2] <= item_i.e2;
        e_q[3] <= item_i.e3;
        e_q[4] <= item_i.e4;
        e_q[5] <= item_i.e5;
        e_q[6] <= item_i.e6;
        e_q[7] <= item_i.e7;
        e_q[8] <= item_i.e8;
        last_q <= item_i.last;
        full_q <= 1'b0;
      end
      bjr_pkg::DP_LOOK: begin
        self_q <= (id_q == self_key);
        if (hit) begin
          slot_q <= hit_slot;
          new_q  <= 1'b0;
        end else begin
          slot_q <= free_slot;
          new_q  <= 1'b1;
          if (!func_q[bjr_pkg::FB_PROD] && (func_q[3:1] == 3'd0)) begin
            if (has_free) key_q[free_slot] <= id_q;
            else full_q <= 1'b1;
          end
        end
      end
      // scale multiplies the read data of the block being scaled
      bjr_pkg::DP_SC_MUL: mul_q  <= ((func_q == bjr_pkg::FN_SCALE_VEL) ? rd_vel_q : rd_pos_q) *
                                    e_q[8];
      bjr_pkg::DP_HD_MUL: mul_q  <= e_q[8] * $signed({1'b0, damp_q});
      bjr_pkg::DP_HD_RND: hd_q   <= bjr_pkg::qround(mul_q);
      bjr_pkg::DP_NH:     nh_q   <= bjr_pkg::sat64(64'(n_prod));
      bjr_pkg::DP_P_M:    m_q    <= m_d;
      bjr_pkg::DP_P_MUL:  mul_q  <= m_q * e_q[{2'b00, col}];
      bjr_pkg::DP_P_ACC:  rsum_q <= rsum_d;
      bjr_pkg::DP_FIN: begin
        out_q.res_x      <= func_q[bjr_pkg::FB_PROD] ? acc_q[0] : 32'sd0;
        out_q.res_y      <= func_q[bjr_pkg::FB_PROD] ? acc_q[1] : 32'sd0;
        out_q.res_z      <= func_q[bjr_pkg::FB_PROD] ? acc_q[2] : 32'sd0;
        out_q.done_res   <= func_q[bjr_pkg::FB_PROD] && last_q;
        out_q.table_full <= full_q;
      end
      default: ;
    endcase
  end

  assign status_o.func     = func_q;
  assign status_o.hit      = hit;
  assign status_o.has_free = has_free;
  assign status_o.out_free = out_free;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

// File: rtl/bjr_ctrl.sv
// ----------------------------------------------------------------------------
// bjr_ctrl: sequencing state machine
// Decodes each transaction and walks the datapath through its steps.
// ----------------------------------------------------------------------------
module bjr_ctrl #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bjr_pkg::dp_status_t            status_i,
  output bjr_pkg::dp_cmd_t               cmd_o,
  output logic [$clog2(MAX_ENTRIES)-1:0] ent_o
);

  localparam int unsigned SW = $clog2(MAX_ENTRIES);
  localparam logic [SW-1:0] ENT_LAST = SW'(MAX_ENTRIES - 1);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_LOOK   = 16'h0002,
    S_ADD_RD = 16'h0004,
    S_ADD_WR = 16'h0008,
    S_CLR    = 16'h0010,
    S_SC_RD  = 16'h0020,
    S_SC_MUL = 16'h0040,
    S_SC_WR  = 16'h0080,
    S_HD_MUL = 16'h0100,
    S_HD_RND = 16'h0200,
    S_NH     = 16'h0400,
    S_P_RD   = 16'h0800,
    S_P_M    = 16'h1000,
    S_P_MUL  = 16'h2000,
    S_P_ACC  = 16'h4000,
    S_FIN    = 16'h8000
  } state_e;

  state_e        state_q, state_d;
  logic [3:0]    elem_q, elem_d;
  logic [SW-1:0] ent_q, ent_d;
  logic          sweep_end;

  assign sweep_end = (elem_q == bjr_pkg::ELEM_LAST) && (ent_q == ENT_LAST);

  always_comb begin
    state_d    = state_q;
    elem_d     = elem_q;
    ent_d      = ent_q;
    cmd_o.op   = bjr_pkg::DP_NOP;
    cmd_o.elem = elem_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        elem_d     = '0;
        ent_d      = '0;
        if (in_valid_i) begin
          cmd_o.op = bjr_pkg::DP_LOAD;
          state_d  = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.op = bjr_pkg::DP_LOOK;
        if (status_i.func[bjr_pkg::FB_PROD]) begin
          state_d = status_i.hit ? S_HD_MUL : S_FIN;
        end else begin
          case (status_i.func)
            bjr_pkg::FN_ADD_POS, bjr_pkg::FN_ADD_VEL:
              state_d = (status_i.hit || status_i.has_free) ? S_ADD_RD : S_FIN;
            bjr_pkg::FN_CLEAR:                          state_d = S_CLR;
            bjr_pkg::FN_SCALE_POS, bjr_pkg::FN_SCALE_VEL: state_d = S_SC_RD;
            default:                                    state_d = S_FIN;
          endcase
        end
      end
      // accumulate one block: read then write each element
      S_ADD_RD: begin
        cmd_o.op = bjr_pkg::DP_ADD_RD;
        state_d  = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd_o.op = bjr_pkg::DP_ADD_WR;
        if (elem_q == bjr_pkg::ELEM_LAST) begin
          state_d = S_FIN;
        end else begin
          elem_d  = elem_q + 4'd1;
          state_d = S_ADD_RD;
        end
      end
      // zero sweep over every element of every entry
      S_CLR: begin
        cmd_o.op = bjr_pkg::DP_CLR_WR;
        if (sweep_end) begin
          state_d = S_FIN;
        end else if (elem_q == bjr_pkg::ELEM_LAST) begin
          elem_d = '0;
          ent_d  = ent_q + SW'(1);
        end else begin
          elem_d = elem_q + 4'd1;
        end
      end
      // scale sweep: read, multiply, write back
      S_SC_RD: begin
        cmd_o.op = bjr_pkg::DP_SC_RD;
        state_d  = S_SC_MUL;
      end
      S_SC_MUL: begin
        cmd_o.op = bjr_pkg::DP_SC_MUL;
        state_d  = S_SC_WR;
      end
      S_SC_WR: begin
        cmd_o.op = bjr_pkg::DP_SC_WR;
        if (sweep_end) begin
          state_d = S_FIN;
        end else begin
          state_d = S_SC_RD;
          if (elem_q == bjr_pkg::ELEM_LAST) begin
            elem_d = '0;
            ent_d  = ent_q + SW'(1);
          end else begin
            elem_d = elem_q + 4'd1;
          end
        end
      end
      // diagonal damping terms
      S_HD_MUL: begin
        cmd_o.op = bjr_pkg::DP_HD_MUL;
        state_d  = S_HD_RND;
      end
      S_HD_RND: begin
        cmd_o.op = bjr_pkg::DP_HD_RND;
        state_d  = S_NH;
      end
      S_NH: begin
        cmd_o.op = bjr_pkg::DP_NH;
        state_d  = S_P_RD;
      end
      // product: one block element per pass
      S_P_RD: begin
        cmd_o.op = bjr_pkg::DP_P_RD;
        state_d  = S_P_M;
      end
      S_P_M: begin
        cmd_o.op = bjr_pkg::DP_P_M;
        state_d  = S_P_MUL;
      end
      S_P_MUL: begin
        cmd_o.op = bjr_pkg::DP_P_MUL;
        state_d  = S_P_ACC;
      end
      S_P_ACC: begin
        cmd_o.op = bjr_pkg::DP_P_ACC;
        if (elem_q == bjr_pkg::ELEM_LAST) begin
          state_d = S_FIN;
        end else begin
          elem_d  = elem_q + 4'd1;
          state_d = S_P_RD;
        end
      end
      // hand the result to the output register once it is free
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.op = bjr_pkg::DP_FIN;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ent_o = ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      elem_q  <= '0;
      ent_q   <= '0;
    end else begin
      state_q <= state_d;
      elem_q  <= elem_d;
      ent_q   <= ent_d;
    end
  end

endmodule

// File: rtl/block_jacobian_row_matvec.sv
// ----------------------------------------------------------------------------
// block_jacobian_row_matvec: block Jacobian row with streamed mat-vec product
// Top level joining the sequencing controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one command transaction (add block, clear, scale, or one
//   product element); out_o returns exactly one result transaction for each.
//   Configuration (self id, mass, damping) is written through cfg_we_i /
//   cfg_idx_i / cfg_data_i while the block is idle.
// Sequencing (one transaction at a time, set by the controller walking the
//   block memories through their single read/write port):
//     add block ............ read and write per element, 9 elements
//     clear ................ zero write per element of every entry
//     scale ................ read, multiply, write per element of every entry
//     product, id found .... damping terms, then read, form, multiply, accumulate per element
//     product miss / other . no memory pass
//   The block is ready for a new transaction in the cycle after the previous
//   result enters the output register.
// Reset clears the key table, counters and accumulator; block memories need
//   no clearing pass. A stalled receiver holds the result in the output
//   register; the next result waits until it is taken.
module block_jacobian_row_matvec #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned ID_WIDTH    = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  bjr_in_if.sink      in_i,
  bjr_out_if.source   out_o
);

  bjr_pkg::dp_cmd_t               cmd;
  bjr_pkg::dp_status_t            status;
  logic [$clog2(MAX_ENTRIES)-1:0] ent;

  bjr_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd),
    .ent_o      (ent)
  );

  bjr_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ID_WIDTH    (ID_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (in_i.data),
    .cmd_i       (cmd),
    .ent_i       (ent),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

// File: bench/block_jacobian_row_matvec_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_jacobian_row_matvec_check: result predictor and comparator
// Watches the command and result channels and keeps its own copy of the key
// table, the Jacobian blocks and the product accumulator. It predicts each
// result and compares it, field by field, with what the block returns.
// ----------------------------------------------------------------------------
module block_jacobian_row_matvec_check #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  bjr_in_if.sink      in_mon,
  bjr_out_if.sink     out_mon,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          done_cnt_o,
  output int          full_cnt_o
);

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  // model state
  logic [19:0]        row_self;
  logic [30:0]        row_mass;
  logic [30:0]        row_damp;
  logic [19:0]        keys  [MAX_ENTRIES];
  logic               kval  [MAX_ENTRIES];
  logic signed [31:0] jpos  [MAX_ENTRIES][9];
  logic signed [31:0] jvel  [MAX_ENTRIES][9];
  logic signed [31:0] acc   [3];
  bjr_pkg::out_item_t expected_q[$];

  function automatic logic signed [31:0] clamp(input longint v);
    if (v > QMAX) return 32'sh7fffffff;
    if (v < QMIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Q16.16 multiply, nearest with ties up
  function automatic logic signed [31:0] fxmul(input longint a, input longint b);
    longint q;
    q = a * b + 64'sd32768;
    return clamp(q >>> 16);
  endfunction

  function automatic int lookup(input logic [19:0] id);
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (kval[i] && keys[i] == id) return i;
    return -1;
  endfunction

  // apply one command to the model and return its result
  function automatic bjr_pkg::out_item_t predict_row(input bjr_pkg::in_item_t it);
    bjr_pkg::out_item_t r;
    longint             ev[9];
    int                 slot;
    r = '0;
    ev = '{it.e0, it.e1, it.e2, it.e3, it.e4, it.e5, it.e6, it.e7, it.e8};
    if (it.func == bjr_pkg::FN_ADD_POS || it.func == bjr_pkg::FN_ADD_VEL) begin
      slot = lookup(it.entry_id);
      if (slot < 0) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (!kval[i]) begin
            slot = i;
            kval[i] = 1'b1;
            keys[i] = it.entry_id;
            for (int j = 0; j < 9; j++) begin
              jpos[i][j] = '0;
              jvel[i][j] = '0;
            end
            break;
          end
        end
      end
      if (slot < 0) r.table_full = 1'b1;
      else
        for (int j = 0; j < 9; j++)
          if (it.func == bjr_pkg::FN_ADD_POS)
            jpos[slot][j] = clamp(longint'(jpos[slot][j]) + ev[j]);
          else jvel[slot][j] = clamp(longint'(jvel[slot][j]) + ev[j]);
    end else if (it.func == bjr_pkg::FN_CLEAR) begin
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (kval[i])
          for (int j = 0; j < 9; j++) begin
            jpos[i][j] = '0;
            jvel[i][j] = '0;
          end
    end else if (it.func == bjr_pkg::FN_SCALE_POS || it.func == bjr_pkg::FN_SCALE_VEL) begin
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (kval[i])
          for (int j = 0; j < 9; j++)
            if (it.func == bjr_pkg::FN_SCALE_POS) jpos[i][j] = fxmul(jpos[i][j], ev[8]);
            else jvel[i][j] = fxmul(jvel[i][j], ev[8]);
    end else if (it.func[bjr_pkg::FB_PROD]) begin
      slot = lookup(it.entry_id);
      if (slot >= 0) begin
        logic signed [31:0] m[9];
        logic signed [31:0] hd;
        longint             add, n, s;
        hd = fxmul(ev[8], longint'(row_damp));
        for (int j = 0; j < 9; j++) begin
          if (it.func[bjr_pkg::FB_AMODE]) begin
            m[j] = clamp(-longint'(jpos[slot][j]));
            if (it.func[bjr_pkg::FB_VEL])
              m[j] = clamp(longint'(m[j]) - longint'(jvel[slot][j]));
          end else m[j] = jpos[slot][j];
        end
        if (keys[slot] == row_self) begin
          add = 0;
          if (it.func[bjr_pkg::FB_AMODE]) begin
            n = -1;
            for (int i = 0; i < MAX_ENTRIES; i++) if (kval[i]) n++;
            for (int j = 0; j < 3; j++)
              m[j*4] = clamp(longint'(m[j*4]) + longint'(row_mass));
            if (it.func[bjr_pkg::FB_DAMP]) add = clamp(n * longint'(hd));
          end else if (it.func[bjr_pkg::FB_DAMP]) add = hd;
          for (int j = 0; j < 3; j++) m[j*4] = clamp(longint'(m[j*4]) + add);
        end
        for (int i = 0; i < 3; i++) begin
          s = longint'(fxmul(m[i*3], ev[0])) + longint'(fxmul(m[i*3+1], ev[1]))
            + longint'(fxmul(m[i*3+2], ev[2]));
          acc[i] = clamp(longint'(acc[i]) + longint'(clamp(s)));
        end
      end
      r.res_x = acc[0];
      r.res_y = acc[1];
      r.res_z = acc[2];
      r.done_res = it.last;
      if (it.last) acc = '{3{32'sd0}};
    end
    return r;
  endfunction

  assign pending_o = expected_q.size();

  // track configuration, predict on command, compare on result
  always @(posedge clk_i or negedge rst_ni) begin
    bjr_pkg::out_item_t want;
    bjr_pkg::out_item_t got;
    if (!rst_ni) begin
      row_self = '0;
      row_mass = bjr_pkg::MASS_RESET;
      row_damp = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) kval[i] = 1'b0;
      acc = '{3{32'sd0}};
      expected_q.delete();
      fail_cnt_o = 0;
      done_cnt_o = 0;
      full_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bjr_pkg::CFG_SELF_ID: row_self = cfg_data_i[19:0];
          bjr_pkg::CFG_MASS:    row_mass = cfg_data_i;
          bjr_pkg::CFG_DAMP:    row_damp = cfg_data_i;
          default:     ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction");
          fail_cnt_o++;
        end else begin
          want = expected_q.pop_front();
          if (got.res_x !== want.res_x) begin
            $error("res_x expected %0d got %0d", want.res_x, got.res_x); fail_cnt_o++;
          end
          if (got.res_y !== want.res_y) begin
            $error("res_y expected %0d got %0d", want.res_y, got.res_y); fail_cnt_o++;
          end
          if (got.res_z !== want.res_z) begin
            $error("res_z expected %0d got %0d", want.res_z, got.res_z); fail_cnt_o++;
          end
          if (got.done_res !== want.done_res) begin
            $error("done_res expected %0b got %0b", want.done_res, got.done_res);
            fail_cnt_o++;
          end
          if (got.table_full !== want.table_full) begin
            $error("table_full expected %0b got %0b", want.table_full, got.table_full);
            fail_cnt_o++;
          end
          if (want.done_res) done_cnt_o++;
          if (want.table_full) full_cnt_o++;
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.insert(expected_q.size(), predict_row(in_mon.data));
    end
  end

endmodule

// File: bench/block_jacobian_row_matvec_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_jacobian_row_matvec_test: stimulus and verdict
// Drives directed and random command transactions (block adds, clears, scales
// and product streams) through several register settings, with random gaps
// and receiver stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module block_jacobian_row_matvec_test;

  localparam int unsigned NENT  = 16;
  localparam int          LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = bjr_pkg::CFG_SELF_ID;
  logic [30:0] cfg_data_i = '0;
  int          fail_cnt, pending, done_cnt, full_cnt;
  int          sent = 0;
  int          idle_cyc = 0;
  bit          quiet = 1'b0;
  bit          calm = 1'b0;
  logic [19:0] id_pool[8];

  bjr_in_if  cmd_ch ();
  bjr_out_if res_ch ();

  always #2 clk_i = ~clk_i;

  block_jacobian_row_matvec #(.MAX_ENTRIES(NENT), .ID_WIDTH(20)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(cmd_ch.sink), .out_o(res_ch.source)
  );

  block_jacobian_row_matvec_check #(.MAX_ENTRIES(NENT)) u_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_mon(cmd_ch.sink), .out_mon(res_ch.sink),
    .fail_cnt_o(fail_cnt), .pending_o(pending),
    .done_cnt_o(done_cnt), .full_cnt_o(full_cnt)
  );

  // receiver: random stall bursts, none once calm
  initial begin
    int n;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        res_ch.ready = 1'b0;
        n = $urandom_range(1, 13);
        repeat (n - 1) @(negedge clk_i);
      end else res_ch.ready = 1'b1;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= LIMIT) begin
      $display("block_jacobian_row_matvec_test NOT OK");
      $finish;
    end
  end

  function automatic logic signed [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 262143)) - 32'sd131072;
      3: return 32'sh00010000;
      default: return $urandom();
    endcase
  endfunction

  function automatic bjr_pkg::in_item_t rnd_item(input logic [3:0] fn);
    bjr_pkg::in_item_t it;
    it.func = fn;
    it.entry_id = ($urandom_range(0, 9) == 0) ? 20'($urandom()) : id_pool[$urandom_range(0, 7)];
    it.e0 = rnd_val(); it.e1 = rnd_val(); it.e2 = rnd_val();
    it.e3 = rnd_val(); it.e4 = rnd_val(); it.e5 = rnd_val();
    it.e6 = rnd_val(); it.e7 = rnd_val(); it.e8 = rnd_val();
    // scale factors near one keep blocks alive
    if (fn == bjr_pkg::FN_SCALE_POS || fn == bjr_pkg::FN_SCALE_VEL)
      it.e8 = ($urandom_range(0, 3) == 0) ? rnd_val() : 32'sd49152 + $urandom_range(0, 32768);
    it.last = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // send one transaction, with an optional gap first
  task automatic send_cmd(input bjr_pkg::in_item_t it);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 13);
      repeat (n) @(negedge clk_i);
    end
    cmd_ch.valid = 1'b1;
    cmd_ch.data = it;
    do @(posedge clk_i); while (!cmd_ch.ready);
    @(negedge clk_i);
    cmd_ch.valid = 1'b0;
    sent++;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (500) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // product stream, mostly over the pool ids, ending with last
  task automatic send_stream(input logic [3:0] fn);
    bjr_pkg::in_item_t it;
    int len;
    len = $urandom_range(1, 6);
    for (int k = 0; k < len; k++) begin
      it = rnd_item(fn);
      it.e8 = $urandom_range(0, 1) ? 32'sd655 + $urandom_range(0, 6000) : rnd_val();
      it.last = (k == len - 1);
      send_cmd(it);
    end
  endtask

  task automatic random_phase(input int count);
    int start;
    start = sent;
    while (sent - start < count) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: send_cmd(rnd_item(4'($urandom_range(0, 1))));
        6:  send_cmd(rnd_item(bjr_pkg::FN_CLEAR));
        7:  send_cmd(rnd_item(4'(bjr_pkg::FN_SCALE_POS + $urandom_range(0, 1))));
        8:  send_cmd(rnd_item(4'($urandom_range(5, 15))));
        default: send_stream(4'(4'd8 + $urandom_range(0, 7)));
      endcase
    end
  endtask

  initial begin
    bjr_pkg::in_item_t it;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    for (int i = 0; i < 8; i++) id_pool[i] = 20'($urandom());
    id_pool[0] = '0;
    id_pool[1] = 20'hfffff;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, every code, self entry, misses, full table
    write_reg(bjr_pkg::CFG_SELF_ID, 31'(id_pool[2]));
    write_reg(bjr_pkg::CFG_DAMP, 31'd32768);
    it = '0;
    it.func = 4'd9; it.entry_id = id_pool[2]; it.e0 = 32'sh10000; it.last = 1'b1;
    send_cmd(it);                                     // miss: absent id
    it = rnd_item(bjr_pkg::FN_ADD_POS); it.entry_id = id_pool[2]; send_cmd(it);
    it = rnd_item(bjr_pkg::FN_ADD_VEL); it.entry_id = id_pool[2]; send_cmd(it);
    it.func = bjr_pkg::FN_ADD_POS; it.entry_id = id_pool[1];
    {it.e0, it.e4, it.e8} = {32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    send_cmd(it); send_cmd(it);                       // saturating add
    for (int f = 8; f < 16; f++) begin
      it = rnd_item(4'(f)); it.entry_id = id_pool[2]; it.e8 = 32'sh8000;
      it.last = (f == 15); send_cmd(it);
    end
    it = rnd_item(4'd12); it.entry_id = id_pool[1]; it.last = 1'b1; send_cmd(it);
    for (int f = 2; f < 8; f++) begin it = rnd_item(4'(f)); it.e8 = 32'sh18000; send_cmd(it); end
    for (int k = 0; k < NENT + 1; k++) begin         // fill past capacity
      it = rnd_item(bjr_pkg::FN_ADD_VEL); it.entry_id = 20'(k * 4099 + 7); send_cmd(it);
    end
    drain();

    // random phases under varied settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(bjr_pkg::CFG_SELF_ID,
                (ph == 1) ? 31'hfffff : 31'(id_pool[$urandom_range(0, 7)]));
      write_reg(bjr_pkg::CFG_MASS,
                (ph == 2) ? 31'h7fffffff : (ph == 3) ? 31'd0 : 31'($urandom()));
      write_reg(bjr_pkg::CFG_DAMP, (ph == 2) ? 31'h7fffffff : (ph == 3) ? 31'd0
                                    : 31'($urandom_range(0, 1 << 20)));
      for (int i = 2; i < 8; i++) id_pool[i] = 20'($urandom());
      if (ph == 4) begin quiet = 1'b1; calm = 1'b1; end
      random_phase(210);
      drain();                                        // sender waits for all results
    end

    $display("covered %0d commands, %0d finished products, %0d dropped adds",
             sent, done_cnt, full_cnt);
    if (fail_cnt == 0) $display("block_jacobian_row_matvec_test OK");
    else $display("block_jacobian_row_matvec_test NOT OK");
    $finish;
  end

endmodule

// File: sim.f
rtl/bjr_pkg.sv
rtl/bjr_if.sv
rtl/bjr_datapath.sv
rtl/bjr_ctrl.sv
rtl/block_jacobian_row_matvec.sv
bench/block_jacobian_row_matvec_check.sv
bench/block_jacobian_row_matvec_test.sv
